// File: rtl/core/modular_exponentiation_macros.svh
// Assertion macros for the modular exponentiation block.
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH
`ifndef SYNTHESIS
`define ME_ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ME_ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
    else $error("assertion failed");
`else
`define ME_ASSERT_IMPL(label, clk, rst_n, prop)
`define ME_ASSERT_NEXT(label, clk, rst_n, cond, nxt)
`endif
`endif

// File: rtl/core/modexp_pkg.sv
// Package with sequencer states and shared types for modular exponentiation.
package modexp_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED_BASE,
    ST_MUL_ACC,
    ST_SQR,
    ST_NEXT,
    ST_DONE
  } state_e;

  // Control and status of the shared modular multiplier
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } mm_ctrl_t;

endpackage

// File: rtl/core/modexp_mulmod.sv
// Shared iterative modular multiplier: shift-add multiply then restoring reduction.
module modexp_mulmod #(
  parameter int W = 31
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [W-1:0]         a_i,
  input  logic [W-1:0]         b_i,
  input  logic [W-1:0]         m_i,
  output modexp_pkg::mm_ctrl_t ctrl_o,
  output logic [W-1:0]         r_o
);
  import modexp_pkg::*;

  localparam int PW = 2 * W;
  localparam int CW = $clog2(PW + 1);

  logic          run_q, run_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] prod_q, prod_d;
  logic [W-1:0]  mult_q, mult_d;
  logic [W:0]    rem_q, rem_d;
  logic [W-1:0]  m_q, m_d;
  logic          phase_q, phase_d;
  logic [W+1:0]  shifted;
  logic [W+1:0]  diff;

  // Multiply phase adds one partial product per cycle; reduce phase takes one
  // product bit per cycle, MSB first.
  always_comb begin
    run_d   = run_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    prod_d  = prod_q;
    mult_d  = mult_q;
    rem_d   = rem_q;
    m_d     = m_q;
    phase_d = phase_q;
    shifted = '0;
    diff    = '0;
    if (start_i && !run_q) begin
      run_d   = 1'b1;
      phase_d = 1'b0;
      cnt_d   = CW'(W);
      prod_d  = '0;
      mult_d  = b_i;
      m_d     = m_i;
      rem_d   = {1'b0, a_i};
    end else if (run_q) begin
      if (!phase_q) begin
        // rem_q holds multiplicand during multiply
        prod_d = {prod_q[PW-2:0], 1'b0} +
                 (mult_q[W-1] ? {{W{1'b0}}, rem_q[W-1:0]} : '0);
        mult_d = {mult_q[W-2:0], 1'b0};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          phase_d = 1'b1;
          cnt_d   = CW'(PW);
          rem_d   = '0;
        end
      end else begin
        shifted = {rem_q, prod_q[PW-1]};
        diff    = shifted - {2'b00, m_q};
        rem_d   = diff[W+1] ? shifted[W:0] : diff[W:0];
        prod_d  = {prod_q[PW-2:0], 1'b0};
        cnt_d   = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_d  = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    prod_q  <= prod_d;
    mult_q  <= mult_d;
    rem_q   <= rem_d;
    m_q     <= m_d;
    phase_q <= phase_d;
  end

  assign ctrl_o.start = start_i;
  assign ctrl_o.busy  = run_q;
  assign ctrl_o.done  = done_q;
  assign r_o          = rem_q[W-1:0];

endmodule

// File: rtl/core/modular_exponentiation.sv
// Modular exponentiation top level: square-and-multiply sequencer.
// Throughput: one item at a time; s_axis_tready is low until the result leaves.
// Reset clears the sequencer and output valid; operand registers are not reset.
module modular_exponentiation #(
  parameter int OPERAND_BITS = 31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [30:0] base_value, [61:31] exponent, [92:62] modulus, [95:93] zero
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [30:0] power_mod, [31] zero
  output logic [31:0] m_axis_tdata
);
  import modexp_pkg::*;
  `include "modular_exponentiation_macros.svh"

  localparam int W  = OPERAND_BITS;
  localparam int BW = $clog2(W + 1);

  state_e        state_q, state_d;
  logic [W-1:0]  base_q, base_d;
  logic [W-1:0]  exp_q, exp_d;
  logic [W-1:0]  mod_q, mod_d;
  logic [W-1:0]  acc_q, acc_d;
  logic [BW-1:0] bit_q, bit_d;
  logic          ovld_q, ovld_d;
  logic [30:0]   res_q, res_d;
  logic          mm_start;
  logic [W-1:0]  mm_a, mm_b;
  logic [W-1:0]  mm_r;
  mm_ctrl_t      mm_ctrl;

  modexp_mulmod #(.W(W)) u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mm_start),
    .a_i    (mm_a),
    .b_i    (mm_b),
    .m_i    (mod_q),
    .ctrl_o (mm_ctrl),
    .r_o    (mm_r)
  );

  assign s_axis_tready = (state_q == ST_IDLE) && !ovld_q;
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {1'b0, res_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    exp_q  <= exp_d;
    mod_q  <= mod_d;
    acc_q  <= acc_d;
    bit_q  <= bit_d;
    res_q  <= res_d;
  end

  // Sequence the modular multiplications over the exponent bits
  always_comb begin
    state_d  = state_q;
    base_d   = base_q;
    exp_d    = exp_q;
    mod_d    = mod_q;
    acc_d    = acc_q;
    bit_d    = bit_q;
    ovld_d   = ovld_q;
    res_d    = res_q;
    mm_start = 1'b0;
    mm_a     = base_q;
    mm_b     = base_q;
    if (ovld_q && m_axis_tready) ovld_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          base_d  = W'(s_axis_tdata[30:0]);
          exp_d   = W'(s_axis_tdata[61:31]);
          mod_d   = W'(s_axis_tdata[92:62]);
          acc_d   = W'(1);
          bit_d   = '0;
          state_d = ST_RED_BASE;
        end
      end
      ST_RED_BASE: begin
        // base * 1 mod m reduces the base
        mm_a = base_q;
        mm_b = W'(1);
        if (mod_q <= W'(1)) begin
          acc_d   = '0;
          state_d = ST_DONE;
        end else if (mm_ctrl.done) begin
          base_d  = mm_r;
          state_d = ST_MUL_ACC;
        end else if (!mm_ctrl.busy) begin
          mm_start = 1'b1;
        end
      end
      ST_MUL_ACC: begin
        mm_a = acc_q;
        mm_b = base_q;
        if (!exp_q[0]) begin
          state_d = ST_SQR;
        end else if (mm_ctrl.done) begin
          acc_d   = mm_r;
          state_d = ST_SQR;
        end else if (!mm_ctrl.busy) begin
          mm_start = 1'b1;
        end
      end
      ST_SQR: begin
        if (exp_q == '0) begin
          state_d = ST_DONE;
        end else if (mm_ctrl.done) begin
          base_d  = mm_r;
          state_d = ST_NEXT;
        end else if (!mm_ctrl.busy) begin
          mm_start = 1'b1;
        end
      end
      ST_NEXT: begin
        exp_d   = exp_q >> 1;
        bit_d   = bit_q + 1'b1;
        state_d = (bit_q == BW'(W - 1)) ? ST_DONE : ST_MUL_ACC;
      end
      ST_DONE: begin
        if (!ovld_q) begin
          res_d   = 31'(acc_q);
          ovld_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `ME_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `ME_ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, (mm_ctrl.busy |-> !s_axis_tready))
  `ME_ASSERT_IMPL(a_start_idle, clk_i, rst_ni, (mm_start |-> !mm_ctrl.busy))

endmodule

// File: tb/modular_exponentiation_tb.sv
// Testbench for the modular exponentiation block: directed table, random items, scoreboard.
module modular_exponentiation_tb;

  localparam int OPERAND_BITS = 31;
  localparam int ITEM_LATENCY = 6000;
  localparam longint CYCLE_LIMIT = 64'd40_000_000;
  localparam int NUM_DIRECTED = 16;
  localparam int NUM_RANDOM = 280;
  localparam logic [30:0] MAX_VAL = 31'h7fff_ffff;

  typedef struct packed {
    logic [30:0] base_value;
    logic [30:0] exponent;
    logic [30:0] modulus;
    logic        has_known;
    logic [30:0] known_result;
  } directed_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  logic [30:0] expected_powers[$];
  int          mismatch_count;
  longint      cycle_count;
  bit          long_hold_req;

  directed_row_t directed_rows[NUM_DIRECTED];

  modular_exponentiation #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Clock with period 8
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Right-to-left square-and-multiply on 62-bit products
  function automatic logic [30:0] power_mod_of(logic [30:0] b, logic [30:0] e,
                                               logic [30:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    if (m <= 31'd1) return '0;
    acc = 64'd1;
    sq = {33'd0, b} % {33'd0, m};
    for (int i = 0; i < OPERAND_BITS; i++) begin
      if (e[i]) acc = (acc * sq) % {33'd0, m};
      sq = (sq * sq) % {33'd0, m};
    end
    return acc[30:0];
  endfunction

  function automatic directed_row_t make_row(logic [30:0] b, logic [30:0] e,
                                             logic [30:0] m, logic k, logic [30:0] r);
    directed_row_t row;
    row.base_value = b;
    row.exponent = e;
    row.modulus = m;
    row.has_known = k;
    row.known_result = r;
    return row;
  endfunction

  // Offer one item after a random gap and wait for its acceptance
  task automatic send_item(logic [30:0] b, logic [30:0] e, logic [30:0] m,
                           logic k, logic [30:0] r);
    int gap;
    gap = $urandom_range(0, 15);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b000, m, e, b};
    expected_powers = {expected_powers, (k ? r : power_mod_of(b, e, m))};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Skew random operands toward small and extreme values
  function automatic logic [30:0] pick_operand();
    case ($urandom_range(0, 5))
      0: return 31'($urandom_range(0, 15));
      1: return MAX_VAL - 31'($urandom_range(0, 15));
      2: return 31'($urandom_range(0, 1023));
      default: return 31'($urandom);
    endcase
  endfunction

  // Cycle counter and timeout
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver readiness: random stalls plus one long hold-off
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (3 * ITEM_LATENCY) @(posedge clk_i);
        long_hold_req = 1'b0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    logic [30:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_powers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected item: power_mod=%0d", m_axis_tdata[30:0]);
      end else begin
        want = expected_powers.pop_front();
        if (m_axis_tdata[30:0] !== want || m_axis_tdata[31] !== 1'b0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("power_mod mismatch: expected %0d, got %0d (tdata %h)",
                     want, m_axis_tdata[30:0], m_axis_tdata);
        end
      end
    end
  end

  initial begin
    directed_row_t row;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    rst_ni = 1'b0;
    mismatch_count = 0;
    cycle_count = 0;
    long_hold_req = 1'b0;

    // Extremes and the special cases of the arithmetic
    directed_rows[0] = make_row(31'd5, 31'd0, 31'd1, 1'b1, 31'd0);
    directed_rows[1] = make_row(MAX_VAL, MAX_VAL, 31'd1, 1'b1, 31'd0);
    directed_rows[2] = make_row(31'd7, 31'd0, 31'd13, 1'b1, 31'd1);
    directed_rows[3] = make_row(31'd0, 31'd0, MAX_VAL, 1'b1, 31'd1);
    directed_rows[4] = make_row(31'd0, 31'd5, 31'd13, 1'b1, 31'd0);
    directed_rows[5] = make_row(31'd3, 31'd5, 31'd0, 1'b1, 31'd0);
    directed_rows[6] = make_row(MAX_VAL, MAX_VAL, 31'd0, 1'b1, 31'd0);
    directed_rows[7] = make_row(31'd2, 31'd10, 31'd1025, 1'b1, 31'd1024);
    directed_rows[8] = make_row(31'd4, 31'd13, 31'd497, 1'b1, 31'd445);
    directed_rows[9] = make_row(MAX_VAL, MAX_VAL, MAX_VAL, 1'b1, 31'd0);
    directed_rows[10] = make_row(MAX_VAL, MAX_VAL, MAX_VAL - 31'd1, 1'b0, '0);
    directed_rows[11] = make_row(MAX_VAL, 31'd1, 31'd2, 1'b1, 31'd1);
    directed_rows[12] = make_row(31'h5555_5555, 31'h2aaa_aaaa, 31'h7fff_ffed, 1'b0, '0);
    directed_rows[13] = make_row(31'h2aaa_aaaa, 31'h5555_5555, 31'h4000_0001, 1'b0, '0);
    directed_rows[14] = make_row(31'd12345, 31'd1, 31'd100, 1'b1, 31'd45);
    directed_rows[15] = make_row(MAX_VAL - 31'd1, 31'd2, MAX_VAL, 1'b1, 31'd1);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_item(row.base_value, row.exponent, row.modulus, row.has_known, row.known_result);
    end

    // Random items; hold off the receiver once and pause the sender until drained once
    for (int n = 0; n < NUM_RANDOM; n++) begin
      logic [30:0] m;
      if (n == 40) long_hold_req = 1'b1;
      if (n == 150) begin
        s_axis_tvalid <= 1'b0;
        while (expected_powers.size() != 0) @(posedge clk_i);
      end
      case ($urandom_range(0, 9))
        0: m = 31'($urandom_range(0, 2));
        1: m = MAX_VAL - 31'($urandom_range(0, 3));
        2: m = 31'($urandom_range(2, 255));
        default: m = 31'($urandom);
      endcase
      send_item(pick_operand(), pick_operand(), m, 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then keep watching for stray results before the verdict
    while (expected_powers.size() != 0) @(posedge clk_i);
    repeat (ITEM_LATENCY) @(posedge clk_i);

    if (mismatch_count == 0 && expected_powers.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
